// ----- design/fxc_pkg.sv -----
// Shared types and constants for the FIX tag=value frame checker.
// No dependencies; used by fxc_core, fxc_outq and the top level.
package fxc_pkg;

    localparam logic [15:0] LENGTH_LIMIT   = 16'hFFFF;
    localparam logic [15:0] MIN_LEN_RESET  = 16'd20;
    localparam logic [7:0]  CH_SOH         = 8'h01;
    localparam logic [7:0]  CH_ZERO        = 8'h30;
    localparam logic [7:0]  CH_ONE         = 8'h31;
    localparam logic [7:0]  CH_EQ          = 8'h3D;
    localparam logic [7:0]  CH_W           = 8'h57;
    localparam logic [7:0]  CH_X           = 8'h58;
    localparam logic [31:0] TAG_MSGTYPE    = 32'd35;
    localparam int          OUT_DATA_W     = 72;
    localparam int          QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        PH_TAG   = 2'd0,
        PH_VALUE = 2'd1,
        PH_HALT  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CHECKSUM  = 3'd2,
        ST_BAD_TAG   = 3'd3,
        ST_NO_TYPE   = 3'd4,
        ST_UNSUPP    = 3'd5,
        ST_TOO_LONG  = 3'd6
    } status_t;

    localparam logic [1:0] MK_NONE  = 2'd0;
    localparam logic [1:0] MK_W     = 2'd1;
    localparam logic [1:0] MK_X     = 2'd2;
    localparam logic [1:0] MK_OTHER = 2'd3;

    typedef struct packed {
        logic        record_kind;
        logic [31:0] tag;
        logic [15:0] val_offset;
        logic [15:0] value_length;
        logic [2:0]  status;
        logic [1:0]  msg_kind;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

// ----- design/fxc_core.sv -----
// Parser and checksum tracker: message state and the results of one byte.
// Depends on fxc_pkg.
module fxc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [15:0]          min_length,
    output fxc_pkg::result_pair_t results
);
    import fxc_pkg::*;

    logic [15:0] bp_reg, bp_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  sh_reg [2], sh_next [2];
    logic [7:0]  pb_reg [2], pb_next [2];
    logic [15:0] tpos_reg [3], tpos_next [3];
    logic [7:0]  tsum_reg [3], tsum_next [3];
    logic [9:0]  trcv_reg [3], trcv_next [3];
    logic [2:0]  tfl_reg [3], tfl_next [3];
    phase_t      ph_reg, ph_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  tf_reg, tf_next;
    logic [15:0] fvs_reg, fvs_next;
    logic        tts_reg, tts_next;
    logic [1:0]  ttk_reg, ttk_next;
    logic [7:0]  vf_reg, vf_next;
    logic        tl_reg, tl_next;

    logic        digit, fld, ck_ok, ck_done;
    logic [15:0] p, flen, len;
    logic [35:0] acc10;
    logic [16:0] trl_gap;
    logic [1:0]  kind;
    result_t     frec, vrec;
    status_t     st;

    always_comb
    begin
        bp_next = bp_reg; sum_next = sum_reg; sh_next = sh_reg; pb_next = pb_reg;
        tpos_next = tpos_reg; tsum_next = tsum_reg; trcv_next = trcv_reg;
        tfl_next = tfl_reg; ph_next = ph_reg; acc_next = acc_reg; tf_next = tf_reg;
        fvs_next = fvs_reg; tts_next = tts_reg; ttk_next = ttk_reg;
        vf_next = vf_reg; tl_next = tl_reg;
        digit = (data_byte >= CH_ZERO) && (data_byte <= 8'h39);
        p = bp_reg;
        acc10 = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
              + {28'd0, data_byte - CH_ZERO};
        fld = 1'b0; flen = '0; kind = MK_OTHER; trl_gap = '0;
        ck_ok = 1'b0; ck_done = 1'b0; len = '0; st = ST_OK;
        frec = '0; vrec = '0;
        results = '0;

        if (!tl_reg && bp_reg == LENGTH_LIMIT)
        begin
            tl_next = 1'b1;
        end
        if (!tl_next)
        begin
            if (ph_reg == PH_TAG)
            begin
                if (data_byte == CH_EQ)
                begin
                    if (tf_reg[0] && !tf_reg[1])
                    begin
                        ph_next = PH_VALUE;
                        fvs_next = p + 16'd1;
                    end
                    else
                    begin
                        ph_next = PH_HALT;
                    end
                end
                else if (!tf_reg[0])
                begin
                    tf_next[0] = 1'b1;
                    if (digit)
                        acc_next = {24'd0, data_byte - CH_ZERO};
                    else
                        tf_next[2:1] = 2'b11;
                end
                else if (!tf_reg[2])
                begin
                    if (digit)
                    begin
                        if (acc10[35:32] != 4'd0)
                            tf_next[2:1] = 2'b11;
                        else
                            acc_next = acc10[31:0];
                    end
                    else
                    begin
                        tf_next[2] = 1'b1;
                    end
                end
            end
            else if (ph_reg == PH_VALUE)
            begin
                if (data_byte == CH_SOH)
                begin
                    fld = 1'b1;
                    flen = p - fvs_reg;
                    ph_next = PH_TAG;
                    acc_next = '0;
                    tf_next = '0;
                end
                else if (p == fvs_reg)
                begin
                    vf_next = data_byte;
                end
            end

            for (int k = 0; k < 3; k++)
            begin
                trl_gap = {1'b0, p} - {1'b0, tpos_reg[k]};
                if (tfl_reg[k][0] && !tfl_reg[k][1] && p > tpos_reg[k]
                    && trl_gap >= 17'd3 && trl_gap <= 17'd5)
                begin
                    if (digit)
                        trcv_next[k] = 10'({trcv_reg[k], 3'b000}
                                     + {1'b0, trcv_reg[k], 1'b0}
                                     + {5'd0, data_byte - CH_ZERO});
                    else
                    begin
                        tfl_next[k][1] = 1'b1;
                        if (trl_gap == 17'd3)
                            tfl_next[k][2] = 1'b1;
                    end
                end
            end
            if (p >= 16'd3 && pb_reg[1] == CH_ONE && pb_reg[0] == CH_ZERO
                && data_byte == CH_EQ)
            begin
                for (int k = 2; k > 0; k--)
                begin
                    tpos_next[k] = tpos_next[k-1];
                    tsum_next[k] = tsum_next[k-1];
                    trcv_next[k] = trcv_next[k-1];
                    tfl_next[k]  = tfl_next[k-1];
                end
                tpos_next[0] = p - 16'd2;
                tsum_next[0] = sh_reg[1];
                trcv_next[0] = '0;
                tfl_next[0]  = 3'b001;
            end
            sh_next[1] = sh_reg[0];
            sh_next[0] = sum_reg;
            sum_next = sum_reg + data_byte;
            pb_next[1] = pb_reg[0];
            pb_next[0] = data_byte;
            bp_next = p + 16'd1;
        end

        len = bp_next;
        if (last_byte && !tl_next && ph_next == PH_VALUE)
        begin
            fld = 1'b1;
            flen = len - fvs_next;
        end
        if (fld)
        begin
            frec.tag = acc_reg;
            frec.val_offset = fvs_next;
            frec.value_length = flen;
            if (acc_reg == TAG_MSGTYPE && !tts_reg)
            begin
                if (flen == 16'd1 && vf_next == CH_W)
                    kind = MK_W;
                else if (flen == 16'd1 && vf_next == CH_X)
                    kind = MK_X;
                tts_next = 1'b1;
                ttk_next = kind;
            end
        end

        if (len >= 16'd7)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (!ck_done && tfl_next[k][0] && tpos_next[k] <= len - 16'd7)
                begin
                    ck_done = 1'b1;
                    ck_ok = !tfl_next[k][2] && (trcv_next[k][7:0] == tsum_next[k]);
                end
            end
        end
        if (tl_next)
            st = ST_TOO_LONG;
        else if (len < min_length)
            st = ST_SHORT;
        else if (!ck_ok)
            st = ST_CHECKSUM;
        else if (ph_next == PH_HALT)
            st = ST_BAD_TAG;
        else if (!tts_next)
            st = ST_NO_TYPE;
        else if (ttk_next == MK_OTHER)
            st = ST_UNSUPP;
        vrec.record_kind = 1'b1;
        vrec.status = st;
        vrec.msg_kind = (st == ST_OK) ? ttk_next : MK_NONE;
        vrec.last_of_run = 1'b1;

        if (fld && last_byte)
        begin
            results.count = 2'd2;
            results.first = frec;
            results.second = vrec;
        end
        else if (fld)
        begin
            frec.last_of_run = 1'b1;
            results.count = 2'd1;
            results.first = frec;
        end
        else if (last_byte)
        begin
            results.count = 2'd1;
            results.first = vrec;
        end

        if (last_byte)
        begin
            bp_next = '0; sum_next = '0; sh_next = '{default: '0};
            pb_next = '{default: '0}; tpos_next = '{default: '0};
            tsum_next = '{default: '0}; trcv_next = '{default: '0};
            tfl_next = '{default: '0}; ph_next = PH_TAG; acc_next = '0;
            tf_next = '0; fvs_next = '0; tts_next = 1'b0; ttk_next = MK_NONE;
            vf_next = '0; tl_next = 1'b0;
        end
        if (!in_fire)
            results.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg <= '0; sum_reg <= '0; sh_reg <= '{default: '0};
            pb_reg <= '{default: '0}; tpos_reg <= '{default: '0};
            tsum_reg <= '{default: '0}; trcv_reg <= '{default: '0};
            tfl_reg <= '{default: '0}; ph_reg <= PH_TAG; acc_reg <= '0;
            tf_reg <= '0; fvs_reg <= '0; tts_reg <= 1'b0; ttk_reg <= MK_NONE;
            vf_reg <= '0; tl_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            bp_reg <= bp_next; sum_reg <= sum_next; sh_reg <= sh_next;
            pb_reg <= pb_next; tpos_reg <= tpos_next; tsum_reg <= tsum_next;
            trcv_reg <= trcv_next; tfl_reg <= tfl_next; ph_reg <= ph_next;
            acc_reg <= acc_next; tf_reg <= tf_next; fvs_reg <= fvs_next;
            tts_reg <= tts_next; ttk_reg <= ttk_next; vf_reg <= vf_next;
            tl_reg <= tl_next;
        end
    end

endmodule

// ----- design/fxc_outq.sv -----
// Result queue that takes up to two results a cycle and hands out one.
// Depends on fxc_pkg.
module fxc_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fxc_pkg::result_pair_t wr,
    output logic                  room,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output fxc_pkg::result_t      rd_data
);
    import fxc_pkg::*;

    result_t    mem_reg [QUEUE_DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign room     = (cnt_reg <= 3'd2);
    assign cnt_next = cnt_reg + {1'b0, wr.count} - {2'd0, pop};

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
            mem_reg[wp_reg] <= wr.first;
        if (wr.count == 2'd2)
            mem_reg[wp_reg + 2'd1] <= wr.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_reg + wr.count;
            rp_reg <= rp_reg + {1'b0, pop};
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- design/fix_tag_value_frame_checker_unit.sv -----
// Top level of the FIX tag=value frame checker: parser core and result queue.
// Depends on fxc_pkg, fxc_core and fxc_outq.
// Each result is registered in the result queue and offered from there.
// Throughput: one byte per cycle while the result queue has room; a byte that yields
// two results takes two queue entries, absorbed by the four-entry result queue.
// Reset clears all message state and sets min_length to 20.
module fix_tag_value_frame_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // tag, value_start, value_length, status, msg_kind, zeros
    output logic        m_tuser,    // record_kind
    output logic        m_tlast,    // last_of_run
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import fxc_pkg::*;

    logic         in_fire, room;
    logic [15:0]  min_len_reg;
    result_pair_t pair;
    result_t      res;

    assign s_tready = room;
    assign in_fire  = s_tvalid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= MIN_LEN_RESET;
        else if (cfg_we)
            min_len_reg <= cfg_wdata;
    end

    fxc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .min_length (min_len_reg),
        .results    (pair)
    );

    fxc_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (pair),
        .room     (room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (res)
    );

    assign m_tdata = {3'd0, res.msg_kind, res.status, res.value_length,
                      res.val_offset, res.tag};
    assign m_tuser = res.record_kind;
    assign m_tlast = res.last_of_run;

endmodule

// ----- design/fxc_checker.sv -----
// Port-level checks for the FIX frame checker, bound to the top level.
// Depends on fix_tag_value_frame_checker_unit.
module fxc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid) else $error("output transfer dropped");
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast) else $error("verdict not last");
    a_field_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[68:64] == 5'd0) else $error("field has status");
    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[68:67] != 2'd0 |-> m_tdata[66:64] == 3'd0)
        else $error("message kind on failed verdict");
endmodule

bind fix_tag_value_frame_checker_unit fxc_checker u_fxc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
